FILE: rtl/mlfs_pkg.sv
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared sizes, event codes and register indexes of the multilevel feedback
// scheduler.
// ----------------------------------------------------------------------------
package mlfs_pkg;

	localparam int MAX_TASKS  = 32;
	localparam int MAX_LEVELS = 4;
	localparam int SLICE_BITS = 10;

	localparam int MODE_W  = 3;
	localparam int ID_W    = 5;
	localparam int LCNT_W  = 3;
	localparam int QUANT_W = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam int IDX_W       = $clog2(MAX_TASKS);
	localparam int FILL_W      = $clog2(MAX_TASKS + 1);
	localparam int LVL_W       = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LVC_W       = $clog2(MAX_LEVELS + 1);
	localparam int STORE_DEPTH = MAX_LEVELS * MAX_TASKS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int SLICE_MAX   = (1 << SLICE_BITS) - 1;

	localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UNBLOCK = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TICK    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_ONE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TWO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_THR = 2'd3;

	localparam logic [LCNT_W-1:0]  RST_LEVEL_COUNT = 3'd4;
	localparam logic [QUANT_W-1:0] RST_QUANTUM_ONE = 10'd2;
	localparam logic [QUANT_W-1:0] RST_QUANTUM_TWO = 10'd4;
	localparam logic [QUANT_W-1:0] RST_QUANTUM_THR = 10'd8;

endpackage

FILE: rtl/mlfs_if.sv
// ----------------------------------------------------------------------------
// mlfs channels
// Valid/ready channels for scheduler events and for chosen tasks.
// ----------------------------------------------------------------------------
interface mlfs_evt_if;
	logic                      valid;
	logic                      ready;
	logic [mlfs_pkg::MODE_W-1:0] mode;
	logic [mlfs_pkg::ID_W-1:0]   task_id;
	logic [mlfs_pkg::ID_W-1:0]   running_id;
	logic                      running_idle;

	modport source(output valid, mode, task_id, running_id, running_idle, input ready);
	modport sink(input valid, mode, task_id, running_id, running_idle, output ready);
endinterface

interface mlfs_pick_if;
	logic                    valid;
	logic                    ready;
	logic [mlfs_pkg::ID_W-1:0] chosen_id;
	logic                    chosen_idle;

	modport source(output valid, chosen_id, chosen_idle, input ready);
	modport sink(input valid, chosen_id, chosen_idle, output ready);
endinterface

FILE: rtl/mlfs_ram.sv
// ----------------------------------------------------------------------------
// mlfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/multilevel_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Single-processor multilevel feedback queue: per-level ready queues in one
// RAM, per-task levels in a second RAM, slice counter in a register.
//
//   channel | dir | handshake     | payload
//   evt     | in  | valid / ready | mode, task_id, running_id, running_idle
//   pick    | out | valid / ready | chosen_id, chosen_idle
//   cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// A reschedule (expired tick, block, exit) steps through level RAM read, queue
// push, ready-store read, level RAM read of the chosen task, and result.
// Reset clears valid bits, queue counters and the slice counter at once;
// the RAMs need no clearing pass. A result waits in the output register; the
// next word is accepted meanwhile and stalls only when it has a result to
// place and the previous one is still untaken.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler (
	input  logic                             clk,
	input  logic                             arst_n,
	mlfs_evt_if.sink                         evt,
	mlfs_pick_if.source                      pick,
	input  logic                             cfg_we,
	input  logic [mlfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FAST,
		S_LVL,
		S_POP,
		S_PICK,
		S_PLVL
	} state_t;

	state_t state_q;

	// configuration
	logic [mlfs_pkg::LCNT_W-1:0]  level_count_q;
	logic [mlfs_pkg::QUANT_W-1:0] quantum_one_q;
	logic [mlfs_pkg::QUANT_W-1:0] quantum_two_q;
	logic [mlfs_pkg::QUANT_W-1:0] quantum_thr_q;

	// scheduler state outside the RAMs
	logic [mlfs_pkg::IDX_W-1:0]      heads_q [mlfs_pkg::MAX_LEVELS];
	logic [mlfs_pkg::FILL_W-1:0]     fill_q  [mlfs_pkg::MAX_LEVELS];
	logic [mlfs_pkg::MAX_TASKS-1:0]  valid_q;
	logic [mlfs_pkg::SLICE_BITS-1:0] slice_q;

	// latched event
	logic [mlfs_pkg::MODE_W-1:0] mode_q;
	logic [mlfs_pkg::ID_W-1:0]   tid_q;
	logic [mlfs_pkg::ID_W-1:0]   rid_q;
	logic                        ridle_q;
	logic                        found_q;
	logic [mlfs_pkg::ID_W-1:0]   pick_id_q;

	// result register
	logic                      out_valid_q;
	logic [mlfs_pkg::ID_W-1:0] out_id_q;
	logic                      out_idle_q;
	logic                      out_load;

	// RAM ports
	logic                         lvl_we;
	logic [mlfs_pkg::IDX_W-1:0]   lvl_waddr;
	logic [mlfs_pkg::LVL_W-1:0]   lvl_wdata;
	logic [mlfs_pkg::IDX_W-1:0]   lvl_raddr;
	logic [mlfs_pkg::LVL_W-1:0]   lvl_rdata;
	logic                         st_we;
	logic [mlfs_pkg::STORE_AW-1:0] st_waddr;
	logic [mlfs_pkg::STORE_AW-1:0] st_raddr;
	logic [mlfs_pkg::ID_W-1:0]    st_rdata;

	// decoded values
	logic                        accept;
	logic                        slot_free;
	logic                        tid_ok;
	logic                        rid_ok;
	logic                        rknown;
	logic [mlfs_pkg::IDX_W-1:0]  tidx;
	logic [mlfs_pkg::IDX_W-1:0]  ridx;
	logic [mlfs_pkg::IDX_W-1:0]  in_tidx;
	logic [mlfs_pkg::IDX_W-1:0]  in_ridx;
	logic [mlfs_pkg::IDX_W-1:0]  pidx;
	logic [mlfs_pkg::LVC_W-1:0]  n_use;
	logic [mlfs_pkg::LVL_W-1:0]  lvl_next;
	logic                        push_req;
	logic [mlfs_pkg::LVL_W-1:0]  push_raw;
	logic [mlfs_pkg::LVL_W-1:0]  push_lvl;
	logic [mlfs_pkg::ID_W-1:0]   push_id;
	logic                        push_ok;
	logic [mlfs_pkg::IDX_W-1:0]  push_slot;
	logic                        pop_any;
	logic [mlfs_pkg::LVL_W-1:0]  pop_lvl;
	logic [mlfs_pkg::LVL_W-1:0]  pick_lvl;
	logic [mlfs_pkg::SLICE_BITS-1:0] slice_load;
	logic                        reschedule_mode;

	assign accept    = evt.valid && evt.ready;
	assign evt.ready = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || pick.ready;
	assign out_load  = slot_free && (state_q == S_FAST || state_q == S_PLVL);

	assign pick.valid       = out_valid_q;
	assign pick.chosen_id   = out_id_q;
	assign pick.chosen_idle = out_idle_q;

	assign reschedule_mode = (evt.mode == mlfs_pkg::MODE_TICK) ||
		(evt.mode == mlfs_pkg::MODE_BLOCK) || (evt.mode == mlfs_pkg::MODE_EXIT);

	assign in_tidx = mlfs_pkg::IDX_W'(32'(evt.task_id));
	assign in_ridx = mlfs_pkg::IDX_W'(32'(evt.running_id));
	assign tidx    = mlfs_pkg::IDX_W'(32'(tid_q));
	assign ridx    = mlfs_pkg::IDX_W'(32'(rid_q));
	assign pidx    = mlfs_pkg::IDX_W'(32'(pick_id_q));
	assign tid_ok  = 32'(tid_q) < mlfs_pkg::MAX_TASKS;
	assign rid_ok  = 32'(rid_q) < mlfs_pkg::MAX_TASKS;
	assign rknown  = !ridle_q && rid_ok && valid_q[ridx];

	// levels in use, clamped to 1..MAX_LEVELS
	always_comb begin
		if (level_count_q == '0) begin
			n_use = mlfs_pkg::LVC_W'(1);
		end else if (32'(level_count_q) > mlfs_pkg::MAX_LEVELS) begin
			n_use = mlfs_pkg::LVC_W'(mlfs_pkg::MAX_LEVELS);
		end else begin
			n_use = mlfs_pkg::LVC_W'(level_count_q);
		end
	end

	// expired tick: drop one level unless already at the last level in use
	assign lvl_next = (32'(lvl_rdata) + 1 < 32'(n_use)) ? lvl_rdata + 1'b1 : lvl_rdata;

	// level RAM and push decisions, valid in S_LVL
	always_comb begin
		lvl_we    = 1'b0;
		lvl_waddr = ridx;
		lvl_wdata = lvl_rdata;
		push_req  = 1'b0;
		push_raw  = '0;
		push_id   = rid_q;
		if (state_q == S_LVL) begin
			unique case (mode_q)
				mlfs_pkg::MODE_LOAD: begin
					if (tid_ok) begin
						lvl_we    = 1'b1;
						lvl_waddr = tidx;
						lvl_wdata = '0;
						push_req  = 1'b1;
						push_id   = tid_q;
					end
				end
				mlfs_pkg::MODE_UNBLOCK: begin
					if (tid_ok && valid_q[tidx]) begin
						push_req = 1'b1;
						push_raw = lvl_rdata;
						push_id  = tid_q;
					end
				end
				mlfs_pkg::MODE_TICK: begin
					if (slice_q == '0 && rknown) begin
						lvl_we    = 1'b1;
						lvl_wdata = lvl_next;
						push_req  = 1'b1;
						push_raw  = lvl_next;
					end
				end
				mlfs_pkg::MODE_BLOCK: begin
					if (rknown && lvl_rdata != '0) begin
						lvl_we    = 1'b1;
						lvl_wdata = lvl_rdata - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// push: clamp the level, drop on a full queue
	always_comb begin
		int slot;
		if (32'(push_raw) >= 32'(n_use)) begin
			push_lvl = mlfs_pkg::LVL_W'(32'(n_use) - 1);
		end else begin
			push_lvl = push_raw;
		end
		push_ok = push_req && (32'(fill_q[push_lvl]) < mlfs_pkg::MAX_TASKS);
		slot = 32'(heads_q[push_lvl]) + 32'(fill_q[push_lvl]);
		if (slot >= mlfs_pkg::MAX_TASKS) begin
			slot = slot - mlfs_pkg::MAX_TASKS;
		end
		push_slot = mlfs_pkg::IDX_W'(slot);
		st_we     = push_ok;
		st_waddr  = mlfs_pkg::STORE_AW'(32'(push_lvl) * mlfs_pkg::MAX_TASKS + 32'(push_slot));
	end

	// pop: first nonempty level wins
	always_comb begin
		pop_any = 1'b0;
		pop_lvl = '0;
		for (int l = mlfs_pkg::MAX_LEVELS - 1; l >= 0; l--) begin
			if (fill_q[l] != '0) begin
				pop_any = 1'b1;
				pop_lvl = mlfs_pkg::LVL_W'(l);
			end
		end
		st_raddr = mlfs_pkg::STORE_AW'(32'(pop_lvl) * mlfs_pkg::MAX_TASKS +
			32'(heads_q[pop_lvl]));
	end

	// level RAM read: the event's task_id or running_id on accept, chosen task in S_PICK,
	// hold the chosen task's address while the result waits
	always_comb begin
		if (state_q == S_PICK) begin
			lvl_raddr = mlfs_pkg::IDX_W'(32'(st_rdata));
		end else if (state_q == S_PLVL) begin
			lvl_raddr = pidx;
		end else if (evt.mode == mlfs_pkg::MODE_LOAD || evt.mode == mlfs_pkg::MODE_UNBLOCK) begin
			lvl_raddr = in_tidx;
		end else begin
			lvl_raddr = in_ridx;
		end
	end

	// slice reload from the chosen task's level
	always_comb begin
		int q;
		pick_lvl = '0;
		if (found_q && valid_q[pidx]) begin
			pick_lvl = lvl_rdata;
		end
		if (pick_lvl == '0) begin
			q = 1;
		end else if (32'(pick_lvl) == 1) begin
			q = 32'(quantum_one_q);
		end else if (32'(pick_lvl) == 2) begin
			q = 32'(quantum_two_q);
		end else begin
			q = 32'(quantum_thr_q);
		end
		if (q > mlfs_pkg::SLICE_MAX) begin
			q = mlfs_pkg::SLICE_MAX;
		end
		slice_load = (q == 0) ? '0 : mlfs_pkg::SLICE_BITS'(q - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			level_count_q <= mlfs_pkg::RST_LEVEL_COUNT;
			quantum_one_q <= mlfs_pkg::RST_QUANTUM_ONE;
			quantum_two_q <= mlfs_pkg::RST_QUANTUM_TWO;
			quantum_thr_q <= mlfs_pkg::RST_QUANTUM_THR;
			for (int l = 0; l < mlfs_pkg::MAX_LEVELS; l++) begin
				heads_q[l] <= '0;
				fill_q[l]  <= '0;
			end
			valid_q     <= '0;
			slice_q     <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mlfs_pkg::CFG_LEVEL_COUNT: level_count_q <= mlfs_pkg::LCNT_W'(cfg_data);
					mlfs_pkg::CFG_QUANTUM_ONE: quantum_one_q <= cfg_data;
					mlfs_pkg::CFG_QUANTUM_TWO: quantum_two_q <= cfg_data;
					mlfs_pkg::CFG_QUANTUM_THR: quantum_thr_q <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pick.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= evt.mode;
						tid_q   <= evt.task_id;
						rid_q   <= evt.running_id;
						ridle_q <= evt.running_idle;
						if (evt.mode == mlfs_pkg::MODE_TICK && slice_q != '0 &&
								!evt.running_idle) begin
							state_q <= S_FAST;
						end else if (evt.mode == mlfs_pkg::MODE_LOAD ||
								evt.mode == mlfs_pkg::MODE_UNBLOCK || reschedule_mode) begin
							state_q <= S_LVL;
						end
					end
				end
				S_FAST: begin
					// keep the running task, count down
					if (slot_free) begin
						out_id_q    <= rid_q;
						out_idle_q  <= 1'b0;
						slice_q     <= slice_q - 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_LVL: begin
					if (lvl_we) begin
						// load revalidates; other writes keep the bit
						valid_q[lvl_waddr] <= 1'b1;
					end
					if (push_ok) begin
						fill_q[push_lvl] <= fill_q[push_lvl] + 1'b1;
					end
					if (mode_q == mlfs_pkg::MODE_LOAD || mode_q == mlfs_pkg::MODE_UNBLOCK) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					found_q <= pop_any;
					if (pop_any) begin
						fill_q[pop_lvl] <= fill_q[pop_lvl] - 1'b1;
						if (32'(heads_q[pop_lvl]) + 1 >= mlfs_pkg::MAX_TASKS) begin
							heads_q[pop_lvl] <= '0;
						end else begin
							heads_q[pop_lvl] <= heads_q[pop_lvl] + 1'b1;
						end
					end
					state_q <= S_PICK;
				end
				S_PICK: begin
					pick_id_q <= st_rdata;
					state_q   <= S_PLVL;
				end
				S_PLVL: begin
					if (slot_free) begin
						out_id_q    <= found_q ? pick_id_q : '0;
						out_idle_q  <= !found_q;
						slice_q     <= slice_load;
						// forget the level only after the chosen task's level is used
						if (mode_q == mlfs_pkg::MODE_EXIT && rknown) begin
							valid_q[ridx] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	mlfs_ram #(
		.WIDTH(mlfs_pkg::LVL_W),
		.DEPTH(mlfs_pkg::MAX_TASKS)
	) u_level_ram (
		.clk  (clk),
		.we   (lvl_we),
		.waddr(lvl_waddr),
		.wdata(lvl_wdata),
		.raddr(lvl_raddr),
		.rdata(lvl_rdata)
	);

	mlfs_ram #(
		.WIDTH(mlfs_pkg::ID_W),
		.DEPTH(mlfs_pkg::STORE_DEPTH)
	) u_ready_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(push_id),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	a_idle_pick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_idle_q) |-> (out_id_q == '0))
		else $error("idle result carries a nonzero task id");

	a_load_validates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LVL && mode_q == mlfs_pkg::MODE_LOAD && tid_ok) |=> valid_q[tidx])
		else $error("loaded task has no valid level");

	a_fast_needs_slice: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FAST) |-> (slice_q != '0 && !ridle_q))
		else $error("slice countdown entered with no slice left");

endmodule
